/* rtl/core/pxas_pkg.sv */
// Shared types and constants for the pad XOR append store unit.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package pxas_pkg;

    localparam int ADDR_BITS_DEFAULT = 40;
    localparam int PTR_W             = 40;
    localparam int NAME_W            = 12;
    localparam int BYTE_W            = 8;
    localparam int WIDTH_W           = 4;
    localparam int XOR_W             = 64;
    localparam int MAXF_W            = 16;
    localparam int ESL_W             = 4;
    localparam int PADL_W            = 5;
    localparam int IDX_W             = 3;
    localparam int QUEUE_DEPTH       = 4;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 112;
    localparam int M_TUSER_W = 3;

    // Fixed part of a table entry: offset word then length word
    localparam logic [PTR_W-1:0] FIXED_PART      = PTR_W'(16);
    localparam logic [PTR_W-1:0] LEN_WORD_OFFSET = PTR_W'(8);
    localparam logic [NAME_W-1:0] NAME_INDEX_MAX = '1;

    localparam logic [WIDTH_W-1:0] WIDTH_BYTE = WIDTH_W'(1);
    localparam logic [WIDTH_W-1:0] WIDTH_WORD = WIDTH_W'(8);

    // Reset values of the configuration registers
    localparam logic [PTR_W-1:0]  RST_FS_LENGTH    = '0;
    localparam logic [PTR_W-1:0]  RST_TABLE_OFFSET = PTR_W'(4096);
    localparam logic [MAXF_W-1:0] RST_MAX_FILES    = MAXF_W'(1);
    localparam logic [ESL_W-1:0]  RST_ENTRY_LOG2   = ESL_W'(6);
    localparam logic [PADL_W-1:0] RST_PAD_LOG2     = PADL_W'(12);
    localparam logic [PTR_W-1:0]  RST_TABLE_START  = PTR_W'(4096);
    localparam logic [PTR_W-1:0]  RST_DATA_START   = PTR_W'(8192);

    typedef enum logic [1:0] {
        OP_OPEN    = 2'd0,
        OP_NAME    = 2'd1,
        OP_DATA    = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NAME_LONG = 2'd2
    } status_t;

    typedef enum logic [IDX_W-1:0] {
        REG_FS_LENGTH    = 3'd0,
        REG_TABLE_OFFSET = 3'd1,
        REG_MAX_FILES    = 3'd2,
        REG_ENTRY_LOG2   = 3'd3,
        REG_PAD_LOG2     = 3'd4,
        REG_TABLE_START  = 3'd5,
        REG_DATA_START   = 3'd6
    } reg_idx_t;

    // Classified command carried from the front to the back
    typedef struct packed {
        op_t               op;
        logic              name_too_long;
        logic [BYTE_W-1:0] byte_value;
    } cmd_t;

    // Static configuration seen by front and back
    typedef struct packed {
        logic [PTR_W-1:0]  fs_length;
        logic [PTR_W-1:0]  table_offset;
        logic [MAXF_W-1:0] max_files;
        logic [ESL_W-1:0]  entry_size_log2;
        logic [PADL_W-1:0] padding_log2;
    } cfg_t;

    // Pointer loads caused by writes of the start registers
    typedef struct packed {
        logic             load_table;
        logic [PTR_W-1:0] table_start;
        logic             load_data;
        logic [PTR_W-1:0] data_start;
    } ptr_load_t;

endpackage

`default_nettype wire

/* rtl/core/pxas_front.sv */
// Front end: accepts input beats and classifies them into commands.
// Depends on pxas_pkg; feeds pxas_queue.
`default_nettype none

module pxas_front
(
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [pxas_pkg::S_TDATA_W-1:0] s_tdata,  // name_length[11:0], byte_value[19:12]
    input  wire logic [pxas_pkg::S_TUSER_W-1:0] s_tuser,  // op[1:0]
    input  wire pxas_pkg::cfg_t                cfg,
    input  wire logic                          queue_full,
    output logic                               push,
    output pxas_pkg::cmd_t                     cmd
);
    import pxas_pkg::*;

    logic [NAME_W-1:0] name_length;
    logic [16:0]       name_need;
    logic [16:0]       entry_bytes;

    assign name_length = s_tdata[NAME_W-1:0];
    // name plus terminator plus fixed part must fit in one entry
    assign name_need   = 17'(name_length) + 17'd1 + 17'(FIXED_PART);
    assign entry_bytes = 17'd1 << cfg.entry_size_log2;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb
    begin
        cmd.op            = op_t'(s_tuser);
        cmd.name_too_long = name_need > entry_bytes;
        cmd.byte_value    = s_tdata[NAME_W +: BYTE_W];
    end

endmodule

`default_nettype wire

/* rtl/core/pxas_queue.sv */
// Short command queue between front and back.
// Depends on pxas_pkg for the command type and depth.
`default_nettype none

module pxas_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire pxas_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output pxas_pkg::cmd_t      head_cmd
);
    import pxas_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = count_reg == CW'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/pxas_back.sv */
// Back end: holds the store pointers, executes commands and registers results.
// Depends on pxas_pkg; pops commands from pxas_queue.
`default_nettype none

module pxas_back
#(
    parameter int ADDR_BITS = pxas_pkg::ADDR_BITS_DEFAULT
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pxas_pkg::cfg_t                cfg,
    input  wire pxas_pkg::ptr_load_t           ptr_load,
    input  wire logic                          head_valid,
    input  wire pxas_pkg::cmd_t                head_cmd,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pxas_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [pxas_pkg::M_TUSER_W-1:0]     m_tuser
);
    import pxas_pkg::*;

    // wrap mask of the address arithmetic
    localparam logic [63:0] AMASK = ~(64'hFFFF_FFFF_FFFF_FFFF << ADDR_BITS);

    logic [PTR_W-1:0]  table_pointer_reg, table_pointer_next;
    logic [PTR_W-1:0]  data_pointer_reg, data_pointer_next;
    logic [PTR_W-1:0]  file_length_reg, file_length_next;
    logic [NAME_W-1:0] name_index_reg, name_index_next;
    logic              open_accepted_reg, open_accepted_next;
    logic [PTR_W:0]    table_end_reg;

    logic              out_valid_reg;
    status_t           out_status_reg, res_status;
    logic              out_we_reg, res_we;
    logic [PTR_W-1:0]  out_addr_reg, res_addr;
    logic [XOR_W-1:0]  out_xor_reg, res_xor;
    logic [WIDTH_W-1:0] out_width_reg, res_width;

    logic [63:0] tp64, dp64, end64, entry64, pad64;
    logic [63:0] name_addr64, len_addr64, tp_step64, dp_step64, dp_round64;
    logic [16:0] name_off;
    logic [16:0] entry17;

    always_comb
    begin
        tp64        = 64'(table_pointer_reg);
        dp64        = 64'(data_pointer_reg);
        entry64     = 64'd1 << cfg.entry_size_log2;
        entry17     = 17'd1 << cfg.entry_size_log2;
        pad64       = 64'd1 << cfg.padding_log2;
        end64       = (64'(cfg.table_offset) + (64'(cfg.max_files) << cfg.entry_size_log2))
                      & AMASK;
        name_off    = 17'(FIXED_PART) + 17'(name_index_reg);
        name_addr64 = (tp64 + 64'(FIXED_PART) + 64'(name_index_reg)) & AMASK;
        len_addr64  = (tp64 + 64'(LEN_WORD_OFFSET)) & AMASK;
        tp_step64   = (tp64 + entry64) & AMASK;
        dp_step64   = (dp64 + 64'd1) & AMASK;
        dp_round64  = ((dp64 + pad64 - 64'd1) & ~(pad64 - 64'd1)) & AMASK;
    end

    assign pop = head_valid && (!out_valid_reg || m_tready);

    // execute the head command
    always_comb
    begin
        table_pointer_next = table_pointer_reg;
        data_pointer_next  = data_pointer_reg;
        file_length_next   = file_length_reg;
        name_index_next    = name_index_reg;
        open_accepted_next = open_accepted_reg;
        res_status         = ST_OK;
        res_we             = 1'b0;
        res_addr           = '0;
        res_xor            = '0;
        res_width          = WIDTH_BYTE;
        case (head_cmd.op)
            OP_OPEN:
            begin
                name_index_next = '0;
                if ({1'b0, table_pointer_reg} == table_end_reg)
                begin
                    open_accepted_next = 1'b0;
                    res_status         = ST_NO_SPACE;
                end
                else if (head_cmd.name_too_long)
                begin
                    open_accepted_next = 1'b0;
                    res_status         = ST_NAME_LONG;
                end
                else
                begin
                    open_accepted_next = 1'b1;
                    res_we             = 1'b1;
                    res_addr           = table_pointer_reg;
                    res_xor            = XOR_W'(data_pointer_reg);
                    res_width          = WIDTH_WORD;
                end
            end
            OP_NAME:
            begin
                if (open_accepted_reg)
                begin
                    if (name_index_reg == NAME_INDEX_MAX || name_off >= entry17)
                    begin
                        res_status = ST_NAME_LONG;
                    end
                    else
                    begin
                        name_index_next = name_index_reg + NAME_W'(1);
                        res_we          = 1'b1;
                        res_addr        = name_addr64[PTR_W-1:0];
                        res_xor         = XOR_W'(head_cmd.byte_value);
                    end
                end
            end
            OP_DATA:
            begin
                if (data_pointer_reg >= cfg.fs_length)
                begin
                    res_status = ST_NO_SPACE;
                end
                else
                begin
                    data_pointer_next = dp_step64[PTR_W-1:0];
                    file_length_next  = file_length_reg + PTR_W'(1);
                    res_we            = 1'b1;
                    res_addr          = data_pointer_reg;
                    res_xor           = XOR_W'(head_cmd.byte_value);
                end
            end
            OP_RELEASE:
            begin
                if (open_accepted_reg)
                begin
                    res_we             = 1'b1;
                    res_addr           = len_addr64[PTR_W-1:0];
                    res_xor            = XOR_W'(file_length_reg);
                    res_width          = WIDTH_WORD;
                    file_length_next   = '0;
                    table_pointer_next = tp_step64[PTR_W-1:0];
                    data_pointer_next  = dp_round64[PTR_W-1:0];
                    open_accepted_next = 1'b0;
                    name_index_next    = '0;
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_pointer_reg <= RST_TABLE_START;
            data_pointer_reg  <= RST_DATA_START;
            file_length_reg   <= '0;
            name_index_reg    <= '0;
            open_accepted_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                table_pointer_reg <= table_pointer_next;
                data_pointer_reg  <= data_pointer_next;
                file_length_reg   <= file_length_next;
                name_index_reg    <= name_index_next;
                open_accepted_reg <= open_accepted_next;
            end
            if (ptr_load.load_table)
            begin
                table_pointer_reg <= ptr_load.table_start;
            end
            if (ptr_load.load_data)
            begin
                data_pointer_reg <= ptr_load.data_start;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and derived table end need no reset
    always_ff @(posedge clk)
    begin
        table_end_reg <= end64[PTR_W:0];
        if (pop)
        begin
            out_status_reg <= res_status;
            out_we_reg     <= res_we;
            out_addr_reg   <= res_addr;
            out_xor_reg    <= res_xor;
            out_width_reg  <= res_width;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_width_reg, out_xor_reg, out_addr_reg};
    assign m_tuser  = {out_we_reg, out_status_reg};

`ifndef SYNTHESIS
    a_name_index_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !open_accepted_reg |-> name_index_reg == '0)
        else $error("name index nonzero without an open file");

    a_no_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_we_reg) |-> (out_addr_reg == '0 && out_width_reg == WIDTH_BYTE))
        else $error("idle result carries address or width");

    a_word_is_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_width_reg == WIDTH_WORD) |-> (out_we_reg && out_status_reg == ST_OK))
        else $error("word width result without a write");

    a_release_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_cmd.op == OP_RELEASE) |=> !open_accepted_reg)
        else $error("file still open after release");
`endif

endmodule

`default_nettype wire

/* rtl/core/pad_xor_append_store_unit.sv */
// Top level of the pad XOR append store unit: configuration registers,
// front, queue and back. Depends on pxas_pkg, pxas_front, pxas_queue, pxas_back.
//
// Usage:
//   s_* carries events (op in s_tuser; name_length and byte_value in s_tdata).
//   Every event gives exactly one result beat on m_*: status and write_enable
//   in m_tuser, write_address, xor_value and write_width in m_tdata. A result
//   with write_enable set commands an XOR of xor_value into the store.
//   cfg_* writes register cfg_index with cfg_data; cfg_ready is always high.
//   Write configuration only while no event is in flight.
// Timing:
//   An accepted beat is written into the queue; the back pops it from the
//   queue head and registers the result, which drives m_tvalid. One beat
//   per cycle is sustained while m_tready stays high; the back updates the
//   pointers as it pops each command.
// Reset and stall:
//   rst_n clears the queue and output, loads the pointers from the reset
//   table and data start values. When m_tready is low the result holds, the
//   queue fills (four commands) and then s_tready drops.
`default_nettype none

module pad_xor_append_store_unit
#(
    parameter int ADDR_BITS = pxas_pkg::ADDR_BITS_DEFAULT
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [pxas_pkg::S_TDATA_W-1:0]  s_tdata,  // name_length[11:0], byte_value[19:12]
    input  wire logic [pxas_pkg::S_TUSER_W-1:0]  s_tuser,  // op[1:0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [pxas_pkg::M_TDATA_W-1:0]       m_tdata,  // write_address[39:0], xor_value[103:40],
                                                           // write_width[107:104]
    output logic [pxas_pkg::M_TUSER_W-1:0]       m_tuser,  // status[1:0], write_enable[2]
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pxas_pkg::IDX_W-1:0]      cfg_index,
    input  wire logic [pxas_pkg::PTR_W-1:0]      cfg_data
);
    import pxas_pkg::*;

    logic [PTR_W-1:0]  fs_length_reg;
    logic [PTR_W-1:0]  table_offset_reg;
    logic [MAXF_W-1:0] max_files_reg;
    logic [ESL_W-1:0]  entry_log2_reg;
    logic [PADL_W-1:0] pad_log2_reg;

    cfg_t      cfg;
    ptr_load_t ptr_load;
    logic      cfg_wr;
    logic      push, queue_full, pop, head_valid;
    cmd_t      push_cmd, head_cmd;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // hold configuration; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_length_reg    <= RST_FS_LENGTH;
            table_offset_reg <= RST_TABLE_OFFSET;
            max_files_reg    <= RST_MAX_FILES;
            entry_log2_reg   <= RST_ENTRY_LOG2;
            pad_log2_reg     <= RST_PAD_LOG2;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(cfg_index))
                REG_FS_LENGTH:    fs_length_reg    <= cfg_data;
                REG_TABLE_OFFSET: table_offset_reg <= cfg_data;
                REG_MAX_FILES:    max_files_reg    <= cfg_data[MAXF_W-1:0];
                REG_ENTRY_LOG2:   entry_log2_reg   <= cfg_data[ESL_W-1:0];
                REG_PAD_LOG2:     pad_log2_reg     <= cfg_data[PADL_W-1:0];
                default:          fs_length_reg    <= fs_length_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.fs_length         = fs_length_reg;
        cfg.table_offset      = table_offset_reg;
        cfg.max_files         = max_files_reg;
        cfg.entry_size_log2   = entry_log2_reg;
        cfg.padding_log2      = pad_log2_reg;
        // start registers load the live pointers directly
        ptr_load.load_table   = cfg_wr && (reg_idx_t'(cfg_index) == REG_TABLE_START);
        ptr_load.table_start  = cfg_data;
        ptr_load.load_data    = cfg_wr && (reg_idx_t'(cfg_index) == REG_DATA_START);
        ptr_load.data_start   = cfg_data;
    end

    pxas_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    pxas_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    pxas_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .ptr_load   (ptr_load),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire
